/* hw/rtl/drk_pkg.sv */
`default_nettype none

package drk_pkg;

	// Request codes carried by req_type.
	localparam logic [1:0] REQ_TICK    = 2'd0;
	localparam logic [1:0] REQ_PRESS   = 2'd1;
	localparam logic [1:0] REQ_RELEASE = 2'd2;

	// Event actions.
	localparam logic ACT_PRESS   = 1'b0;
	localparam logic ACT_RELEASE = 1'b1;

	// Configuration register indexes.
	localparam logic [2:0] CFG_TIMEOUT = 3'd0;
	localparam logic [2:0] CFG_USB     = 3'd1;
	localparam logic [2:0] CFG_GUI     = 3'd2;
	localparam logic [2:0] CFG_CTRL    = 3'd3;
	localparam logic [2:0] CFG_SHIFT   = 3'd4;
	localparam logic [2:0] CFG_ALT     = 3'd5;
	localparam logic [2:0] CFG_ALTGR   = 3'd6;

	// Modifier roles and their slots in the code table.
	localparam int MOD_ROLES = 5;
	localparam logic [2:0] MOD_GUI   = 3'd0;
	localparam logic [2:0] MOD_CTRL  = 3'd1;
	localparam logic [2:0] MOD_SHIFT = 3'd2;
	localparam logic [2:0] MOD_ALT   = 3'd3;
	localparam logic [2:0] MOD_ALTGR = 3'd4;

	localparam logic [7:0] MOD_FIRST   = 8'd19;
	localparam logic [7:0] LAYER_FIRST = 8'd24;

	localparam int CNT_W = 8;
	localparam int CD_W  = 11;
	localparam int LOAD_W = 13;
	localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;
	localparam logic [CD_W-1:0]  CD_MAX  = 11'd2047;

	localparam int MAX_RES = 3;

	typedef struct packed {
		logic [7:0]                     timeout;
		logic                           usb_present;
		logic [MOD_ROLES-1:0][7:0]      mod_codes;
	} cfg_t;

	typedef struct packed {
		logic       action;
		logic [7:0] code;
		logic       is_layer;
		logic       last;
	} res_t;

	typedef struct packed {
		logic [1:0]              cnt;
		res_t [MAX_RES-1:0]      res;
	} batch_t;

	function automatic res_t mk_res(logic action, logic [7:0] code, logic is_layer,
		logic last);
		res_t r;
		r.action   = action;
		r.code     = code;
		r.is_layer = is_layer;
		r.last     = last;
		return r;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/drk_core.sv */
`default_nettype none

// Role state and the step that handles one registered request.
module drk_core #(
	parameter int LAYER_ROLES   = 6,
	parameter int TIMEOUT_SCALE = 5
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              fire,
	input  wire logic [1:0]        req,
	input  wire logic [7:0]        key_code,
	input  wire logic [7:0]        key_type,
	input  wire drk_pkg::cfg_t     cfg,
	output drk_pkg::batch_t        batch
);

	localparam int ROLE_COUNT = drk_pkg::MOD_ROLES + LAYER_ROLES;
	localparam int RW = $clog2(ROLE_COUNT);
	localparam logic [7:0] LAYER_N = 8'(LAYER_ROLES);
	localparam logic [drk_pkg::LOAD_W-1:0] SCALE = drk_pkg::LOAD_W'(TIMEOUT_SCALE);

	logic [drk_pkg::CNT_W-1:0] hold_q [ROLE_COUNT];
	logic [drk_pkg::CD_W-1:0]  cd_q   [ROLE_COUNT];
	logic                      okp_q;

	logic [7:0]                mod_off;
	logic [7:0]                lay_off;
	logic                      is_mod;
	logic                      is_lay;
	logic                      act;
	logic [RW-1:0]             role;
	logic [2:0]                mod_idx;
	logic [7:0]                role_code;
	logic [drk_pkg::CNT_W-1:0] hold_cur;
	logic [drk_pkg::CD_W-1:0]  cd_cur;
	logic [drk_pkg::LOAD_W-1:0] load;
	logic [drk_pkg::CD_W-1:0]  load_sat;
	logic [1:0]                n;

	always_comb begin
		mod_off = key_type - drk_pkg::MOD_FIRST;
		lay_off = key_type - drk_pkg::LAYER_FIRST;
		is_mod  = (key_type >= drk_pkg::MOD_FIRST) && (mod_off < 8'(drk_pkg::MOD_ROLES));
		is_lay  = (key_type >= drk_pkg::LAYER_FIRST) && (lay_off < LAYER_N);
		act     = cfg.usb_present && (is_mod || is_lay);
		mod_idx = is_mod ? mod_off[2:0] : 3'd0;
		if (is_mod) begin
			role = RW'(mod_off);
		end else if (is_lay) begin
			role = RW'(lay_off) + RW'(drk_pkg::MOD_ROLES);
		end else begin
			role = '0;
		end
		role_code = is_mod ? cfg.mod_codes[mod_idx] : lay_off;
		hold_cur  = hold_q[role];
		cd_cur    = cd_q[role];
		load      = {{(drk_pkg::LOAD_W-8){1'b0}}, cfg.timeout} * SCALE;
		load_sat  = (load > drk_pkg::LOAD_W'(drk_pkg::CD_MAX)) ? drk_pkg::CD_MAX
			: load[drk_pkg::CD_W-1:0];

		batch = '0;
		n     = '0;
		unique case (req)
			drk_pkg::REQ_PRESS: begin
				if (act) begin
					if (hold_cur == '0) begin
						batch.res[0] = drk_pkg::mk_res(drk_pkg::ACT_PRESS, role_code, !is_mod,
							1'b1);
					end else begin
						batch.res[0] = drk_pkg::mk_res(drk_pkg::ACT_PRESS, key_code, 1'b0, 1'b1);
					end
					batch.cnt = 2'd1;
				end
			end
			drk_pkg::REQ_RELEASE: begin
				if (act) begin
					// The role lets go only as its count drops from one to zero.
					if (hold_cur == drk_pkg::CNT_W'(1)) begin
						batch.res[n] = drk_pkg::mk_res(drk_pkg::ACT_RELEASE, role_code, !is_mod,
							1'b0);
						n = n + 2'd1;
					end
					if (!okp_q && cd_cur != '0) begin
						batch.res[n] = drk_pkg::mk_res(drk_pkg::ACT_PRESS, key_code, 1'b0, 1'b0);
						n = n + 2'd1;
					end
					batch.res[n] = drk_pkg::mk_res(drk_pkg::ACT_RELEASE, key_code, 1'b0, 1'b1);
					batch.cnt = n + 2'd1;
				end
			end
			default: begin
				batch = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ROLE_COUNT; i++) begin
				hold_q[i] <= '0;
				cd_q[i]   <= '0;
			end
			okp_q <= 1'b0;
		end else if (fire) begin
			case (req)
				drk_pkg::REQ_TICK: begin
					for (int i = 0; i < ROLE_COUNT; i++) begin
						if (cd_q[i] != '0) begin
							cd_q[i] <= cd_q[i] - drk_pkg::CD_W'(1);
						end
					end
				end
				drk_pkg::REQ_PRESS: begin
					// Any press marks another key; the first press of a role clears it.
					okp_q <= !(act && hold_cur == '0);
					if (act) begin
						if (hold_cur == '0) begin
							cd_q[role] <= load_sat;
						end
						if (hold_cur != drk_pkg::CNT_MAX) begin
							hold_q[role] <= hold_cur + drk_pkg::CNT_W'(1);
						end
					end
				end
				drk_pkg::REQ_RELEASE: begin
					if (act && hold_cur != '0) begin
						hold_q[role] <= hold_cur - drk_pkg::CNT_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/drk_outq.sv */
`default_nettype none

// Result register: holds one batch of up to three words and shifts them out.
module drk_outq (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire drk_pkg::batch_t   batch,
	input  wire logic              out_ready,
	output logic                   out_valid,
	output logic                   free,
	output drk_pkg::res_t          head
);

	drk_pkg::res_t [drk_pkg::MAX_RES-1:0] q_q;
	logic [1:0]                           cnt_q;
	logic                                 pop;

	assign out_valid = (cnt_q != 2'd0);
	assign pop       = out_valid && out_ready;
	assign free      = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_ready);
	assign head      = q_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= batch.cnt;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			q_q <= batch.res;
		end else if (pop) begin
			q_q[0] <= q_q[1];
			q_q[1] <= q_q[2];
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/dual_role_key_tap_hold_top.sv */
`default_nettype none

// Channel   | Handshake             | Payload
// ----------+-----------------------+------------------------------------------
// input     | in_valid / in_ready   | req_type, key_code, key_type
// result    | out_valid / out_ready | out_action, out_code, out_is_layer, last
// config    | cfg_we                | cfg_index, cfg_data
//
// An accepted word lands in the input register and is processed once the result
// register is empty or about to empty. Its results (none to three) come out one
// per cycle while out_ready is high; ticks, ordinary keys and disabled roles
// give none.
// Reset clears the role counters, the tap countdowns and the other-key flag, and
// returns the registers to their defaults (usb_present high, the rest zero).
// A stalled result port holds the input register, which in turn drops in_ready.
module dual_role_key_tap_hold_top #(
	parameter int LAYER_ROLES   = 6,
	parameter int TIMEOUT_SCALE = 5
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] req_type,
	input  wire logic [7:0] key_code,
	input  wire logic [7:0] key_type,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            out_action,
	output logic [7:0]      out_code,
	output logic            out_is_layer,
	output logic            last,
	input  wire logic       cfg_we,
	input  wire logic [2:0] cfg_index,
	input  wire logic [7:0] cfg_data
);

	drk_pkg::cfg_t   cfg_q;
	logic            vld_s1;
	logic [1:0]      req_s1;
	logic [7:0]      code_s1;
	logic [7:0]      type_s1;
	logic            free;
	logic            fire;
	drk_pkg::batch_t batch;
	drk_pkg::res_t   head;

	// The registered word moves on whenever the result register can take its batch.
	assign fire     = vld_s1 && free;
	assign in_ready = !vld_s1 || free;

	// Configuration registers; writes to unused indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout     <= '0;
			cfg_q.usb_present <= 1'b1;
			cfg_q.mod_codes   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				drk_pkg::CFG_TIMEOUT: cfg_q.timeout <= cfg_data;
				drk_pkg::CFG_USB:     cfg_q.usb_present <= cfg_data[0];
				drk_pkg::CFG_GUI:     cfg_q.mod_codes[drk_pkg::MOD_GUI] <= cfg_data;
				drk_pkg::CFG_CTRL:    cfg_q.mod_codes[drk_pkg::MOD_CTRL] <= cfg_data;
				drk_pkg::CFG_SHIFT:   cfg_q.mod_codes[drk_pkg::MOD_SHIFT] <= cfg_data;
				drk_pkg::CFG_ALT:     cfg_q.mod_codes[drk_pkg::MOD_ALT] <= cfg_data;
				drk_pkg::CFG_ALTGR:   cfg_q.mod_codes[drk_pkg::MOD_ALTGR] <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Input register. Its valid bit is control state; the payload needs no reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1  <= req_type;
			code_s1 <= key_code;
			type_s1 <= key_type;
		end
	end

	// Role state and the per-word step that forms the batch of results.
	drk_core #(
		.LAYER_ROLES   (LAYER_ROLES),
		.TIMEOUT_SCALE (TIMEOUT_SCALE)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.req      (req_s1),
		.key_code (code_s1),
		.key_type (type_s1),
		.cfg      (cfg_q),
		.batch    (batch)
	);

	// Result register that drains the batch one word per cycle while out_ready is high.
	drk_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire),
		.batch     (batch),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.free      (free),
		.head      (head)
	);

	assign out_action   = head.action;
	assign out_code     = head.code;
	assign out_is_layer = head.is_layer;
	assign last         = head.last;

endmodule

`default_nettype wire

/* tb/tb_dual_role_key_tap_hold_top.sv */
`default_nettype none

// Self-checking bench for the dual-role key block.
//
// An initial block builds the stimulus phase by phase and pushes words into a
// queue. A clocked driver takes words from that queue and offers them on the
// input channel. A clocked monitor does two things at every edge. First it
// compares each accepted result with the oldest predicted event. Then it feeds
// each accepted input word to the local key-role predictor, which appends the
// events that word must cause. Keeping both in one process means a result and
// a prediction never race within a time step.
//
// Between phases the sender pauses until every predicted event has arrived.
// Then, after a short settle for words that cause no events, the registers are
// rewritten. One phase starts with the receiver holding off for a long stretch
// while the sender keeps offering, so the block fills up and drops in_ready.
module tb_dual_role_key_tap_hold_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LAYER_ROLES   = 6;
	localparam int TIMEOUT_SCALE = 5;
	localparam int ROLE_COUNT    = drk_pkg::MOD_ROLES + LAYER_ROLES;
	localparam int STALL_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 8;
	localparam int RX_HOLD_LEN   = 200;
	localparam int MAX_REPORTS   = 10;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0] req;
		logic [7:0] code;
		logic [7:0] kind;
	} key_word_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [1:0] req_type = drk_pkg::REQ_TICK;
	logic [7:0] key_code = 8'd0;
	logic [7:0] key_type = 8'd0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       out_action;
	logic [7:0] out_code;
	logic       out_is_layer;
	logic       last;
	logic       cfg_we = 1'b0;
	logic [2:0] cfg_index = drk_pkg::CFG_TIMEOUT;
	logic [7:0] cfg_data = 8'd0;

	dual_role_key_tap_hold_top #(
		.LAYER_ROLES  (LAYER_ROLES),
		.TIMEOUT_SCALE(TIMEOUT_SCALE)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.key_code    (key_code),
		.key_type    (key_type),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_action  (out_action),
		.out_code    (out_code),
		.out_is_layer(out_is_layer),
		.last        (last),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #2 clk = ~clk;

	// Words waiting to be offered, and events the block still owes us.
	key_word_t      key_words[$];
	drk_pkg::res_t  key_events_due[$];
	key_word_t      next_word;

	// Predictor copy of the registers and of the per-role state.
	logic [7:0]                tap_window = 8'd0;
	logic                      roles_on = 1'b1;
	logic [7:0]                mod_code[drk_pkg::MOD_ROLES] = '{default: 8'd0};
	logic [drk_pkg::CNT_W-1:0] held[ROLE_COUNT] = '{default: '0};
	logic [drk_pkg::CD_W-1:0]  tap_left[ROLE_COUNT] = '{default: '0};
	logic                      other_pressed = 1'b0;

	// Traffic shaping: the stimulus process sets these; the receiver keeps the hold-off counts.
	logic gaps_on = 1'b1;
	int   rx_holds_asked = 0;
	int   rx_holds_done = 0;
	int   rx_hold_left = 0;

	int fail_count = 0;
	int stall_cycles = 0;

	// Map a key type to its role slot: modifiers first, then layers.
	// Anything else is an ordinary key and gets -1.
	function automatic int role_of(logic [7:0] kind);
		if (kind >= drk_pkg::MOD_FIRST
			&& int'(kind) < int'(drk_pkg::MOD_FIRST) + drk_pkg::MOD_ROLES)
			return int'(kind) - int'(drk_pkg::MOD_FIRST);
		if (kind >= drk_pkg::LAYER_FIRST
			&& int'(kind) < int'(drk_pkg::LAYER_FIRST) + LAYER_ROLES)
			return drk_pkg::MOD_ROLES + int'(kind) - int'(drk_pkg::LAYER_FIRST);
		return -1;
	endfunction

	function automatic drk_pkg::res_t plain_event(logic act, logic [7:0] code);
		drk_pkg::res_t ev;
		ev.action   = act;
		ev.code     = code;
		ev.is_layer = 1'b0;
		ev.last     = 1'b0;
		return ev;
	endfunction

	// A role event names the configured modifier code, or the layer index.
	function automatic drk_pkg::res_t role_event(int role, logic act);
		drk_pkg::res_t ev;
		ev.action = act;
		ev.last   = 1'b0;
		if (role < drk_pkg::MOD_ROLES) begin
			ev.code     = mod_code[role];
			ev.is_layer = 1'b0;
		end else begin
			ev.code     = 8'(role - drk_pkg::MOD_ROLES);
			ev.is_layer = 1'b1;
		end
		return ev;
	endfunction

	// Advance the role state by one accepted word and append the events it causes.
	task automatic predict_key_events(input logic [1:0] rq, input logic [7:0] code,
		input logic [7:0] kind);
		drk_pkg::res_t evs[$];
		int            role;
		int            load;
		role = role_of(kind);
		load = int'(tap_window) * TIMEOUT_SCALE;
		if (rq == drk_pkg::REQ_TICK) begin
			for (int i = 0; i < ROLE_COUNT; i++)
				if (tap_left[i] != 0)
					tap_left[i] = tap_left[i] - 1'b1;
			return;
		end
		if (rq != drk_pkg::REQ_PRESS && rq != drk_pkg::REQ_RELEASE)
			return;
		// Any press counts as another key, even an ordinary one or with roles off.
		if (rq == drk_pkg::REQ_PRESS)
			other_pressed = 1'b1;
		if (!roles_on || role < 0)
			return;
		if (rq == drk_pkg::REQ_PRESS) begin
			if (held[role] == 0) begin
				evs.push_back(role_event(role, drk_pkg::ACT_PRESS));
				other_pressed = 1'b0;
				tap_left[role] = (load > int'(drk_pkg::CD_MAX)) ? drk_pkg::CD_MAX
					: drk_pkg::CD_W'(load);
			end else begin
				evs.push_back(plain_event(drk_pkg::ACT_PRESS, code));
			end
			if (held[role] != drk_pkg::CNT_MAX)
				held[role] = held[role] + 1'b1;
		end else begin
			// The count never goes below zero; the role lets go only on 1 to 0.
			if (held[role] != 0) begin
				held[role] = held[role] - 1'b1;
				if (held[role] == 0)
					evs.push_back(role_event(role, drk_pkg::ACT_RELEASE));
			end
			if (!other_pressed && tap_left[role] != 0)
				evs.push_back(plain_event(drk_pkg::ACT_PRESS, code));
			evs.push_back(plain_event(drk_pkg::ACT_RELEASE, code));
		end
		evs[evs.size() - 1].last = 1'b1;
		foreach (evs[i])
			key_events_due.push_back(evs[i]);
	endtask

	// Sender: a new word goes out only when the slot is free after this edge,
	// so valid and the payload hold steady until the word is taken.
	always @(posedge clk) begin
		if (arst_n && (!in_valid || in_ready)) begin
			if (key_words.size() != 0 && !(gaps_on && $urandom_range(99) < 23)) begin
				next_word = key_words.pop_front();
				in_valid <= 1'b1;
				req_type <= next_word.req;
				key_code <= next_word.code;
				key_type <= next_word.kind;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: a requested hold-off drops ready for a long counted stretch;
	// otherwise ready follows the random gap pattern.
	always @(posedge clk) begin
		if (rx_hold_left != 0) begin
			rx_hold_left <= rx_hold_left - 1;
			out_ready <= 1'b0;
		end else if (rx_holds_done != rx_holds_asked) begin
			rx_holds_done <= rx_holds_done + 1;
			rx_hold_left <= RX_HOLD_LEN;
			out_ready <= 1'b0;
		end else begin
			out_ready <= arst_n && !(gaps_on && $urandom_range(99) < 23);
		end
	end

	// Checker and predictor. Results are checked before new predictions are
	// appended; an input word passes the input and result registers before any result.
	always @(posedge clk) begin
		drk_pkg::res_t got;
		drk_pkg::res_t want;
		if (arst_n && out_valid && out_ready) begin
			got.action   = out_action;
			got.code     = out_code;
			got.is_layer = out_is_layer;
			got.last     = last;
			if (key_events_due.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("unexpected word: action %0d code %02h layer %0d last %0d",
						got.action, got.code, got.is_layer, got.last);
			end else begin
				want = key_events_due.pop_front();
				if (got !== want) begin
					fail_count++;
					// Fields are action/code/layer/last.
					if (fail_count <= MAX_REPORTS)
						$display("mismatch: expected %0d/%02h/%0d/%0d got %0d/%02h/%0d/%0d",
							want.action, want.code, want.is_layer, want.last,
							got.action, got.code, got.is_layer, got.last);
				end
			end
		end
		if (arst_n && in_valid && in_ready)
			predict_key_events(req_type, key_code, key_type);
	end

	// Count cycles in which neither channel moves a word.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("dual_role_key_tap_hold_top test failed");
		$finish;
	end

	task automatic queue_word(input logic [1:0] rq, input logic [7:0] code,
		input logic [7:0] kind);
		key_word_t w;
		w.req  = rq;
		w.code = code;
		w.kind = kind;
		key_words.push_back(w);
	endtask

	// Wait until the sender is empty and every predicted word has come back,
	// then give words without events time to leave the pipeline.
	task automatic wait_drained();
		@(negedge clk);
		while (key_words.size() != 0 || in_valid || key_events_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Write all seven registers back to back, mirroring them in the predictor.
	task automatic load_settings(input logic [7:0] window, input logic usb,
		input logic [7:0] gui, input logic [7:0] ctrl, input logic [7:0] shift,
		input logic [7:0] alt, input logic [7:0] altgr);
		logic [7:0] vals[7];
		vals = '{window, {7'd0, usb}, gui, ctrl, shift, alt, altgr};
		for (int i = 0; i < 7; i++) begin
			@(posedge clk);
			cfg_we    <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data  <= vals[i];
			case (3'(i))
				drk_pkg::CFG_TIMEOUT: tap_window = vals[i];
				drk_pkg::CFG_USB:     roles_on = vals[i][0];
				default:              mod_code[i - int'(drk_pkg::CFG_GUI)] = vals[i];
			endcase
		end
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [7:0] any_role_type();
		return 8'($urandom_range(int'(drk_pkg::MOD_FIRST),
			int'(drk_pkg::LAYER_FIRST) + LAYER_ROLES - 1));
	endfunction

	// Ordinary key types: anything random, moved out of the role range if it lands there.
	function automatic logic [7:0] plain_type();
		logic [7:0] kind;
		kind = 8'($urandom_range(255));
		if (role_of(kind) >= 0)
			kind = kind ^ 8'h80;
		return kind;
	endfunction

	// Mostly well-formed tap and hold sequences with random content, plus tick
	// bursts, ordinary keys, stray releases and unused request codes as noise.
	// Unused request codes do not count toward the target.
	task automatic queue_random_words(input int target);
		int         made;
		int         pick;
		int         ticks;
		logic       nested;
		logic [7:0] kind;
		logic [7:0] code;
		made = 0;
		while (made < target) begin
			pick = $urandom_range(99);
			kind = any_role_type();
			code = 8'($urandom_range(255));
			if (pick < 60) begin
				nested = ($urandom_range(99) < 20);
				queue_word(drk_pkg::REQ_PRESS, code, kind);
				made++;
				if (nested) begin
					queue_word(drk_pkg::REQ_PRESS, 8'($urandom_range(255)), kind);
					made++;
				end
				if ($urandom_range(99) < 25) begin
					queue_word(drk_pkg::REQ_PRESS, 8'($urandom_range(255)), plain_type());
					made++;
				end
				ticks = $urandom_range(14);
				repeat (ticks)
					queue_word(drk_pkg::REQ_TICK, 8'($urandom_range(255)),
						8'($urandom_range(255)));
				made += ticks;
				if (nested) begin
					queue_word(drk_pkg::REQ_RELEASE, 8'($urandom_range(255)), kind);
					made++;
				end
				queue_word(drk_pkg::REQ_RELEASE, code, kind);
				made++;
			end else if (pick < 72) begin
				ticks = $urandom_range(1, 6);
				repeat (ticks)
					queue_word(drk_pkg::REQ_TICK, 8'($urandom_range(255)),
						8'($urandom_range(255)));
				made += ticks;
			end else if (pick < 84) begin
				kind = plain_type();
				queue_word(drk_pkg::REQ_PRESS, code, kind);
				queue_word(drk_pkg::REQ_RELEASE, code, kind);
				made += 2;
			end else if (pick < 92) begin
				queue_word(REQ_UNUSED, code, 8'($urandom_range(255)));
			end else begin
				// Broken sequence: a lone release or a lone press of a role.
				queue_word(($urandom_range(1) != 0) ? drk_pkg::REQ_RELEASE
					: drk_pkg::REQ_PRESS, code, kind);
				made++;
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part. The window is one unit, so five ticks close it.
		load_settings(8'd1, 1'b1, 8'h00, 8'hE0, 8'hE1, 8'hE2, 8'hFF);
		queue_word(drk_pkg::REQ_PRESS, 8'h00, 8'h00);
		queue_word(drk_pkg::REQ_RELEASE, 8'hFF, 8'hFF);
		queue_word(drk_pkg::REQ_TICK, 8'h55, 8'hAA);
		queue_word(REQ_UNUSED, 8'hAA, drk_pkg::MOD_FIRST);
		// A quick tap of the GUI role: role press, then role release, tap, plain release.
		queue_word(drk_pkg::REQ_PRESS, 8'h11, drk_pkg::MOD_FIRST + drk_pkg::MOD_GUI);
		queue_word(drk_pkg::REQ_RELEASE, 8'h11, drk_pkg::MOD_FIRST + drk_pkg::MOD_GUI);
		// AltGr pressed twice: the second press is the plain key and blocks the tap.
		queue_word(drk_pkg::REQ_PRESS, 8'h22, drk_pkg::MOD_FIRST + drk_pkg::MOD_ALTGR);
		queue_word(drk_pkg::REQ_PRESS, 8'h23, drk_pkg::MOD_FIRST + drk_pkg::MOD_ALTGR);
		queue_word(drk_pkg::REQ_RELEASE, 8'h23, drk_pkg::MOD_FIRST + drk_pkg::MOD_ALTGR);
		queue_word(drk_pkg::REQ_RELEASE, 8'h22, drk_pkg::MOD_FIRST + drk_pkg::MOD_ALTGR);
		// The first layer held past its window gives no tap.
		queue_word(drk_pkg::REQ_PRESS, 8'h33, drk_pkg::LAYER_FIRST);
		repeat (6) queue_word(drk_pkg::REQ_TICK, 8'hFF, 8'h00);
		queue_word(drk_pkg::REQ_RELEASE, 8'h33, drk_pkg::LAYER_FIRST);
		// The last layer interrupted by an ordinary key gives no tap either.
		queue_word(drk_pkg::REQ_PRESS, 8'h44,
			8'(int'(drk_pkg::LAYER_FIRST) + LAYER_ROLES - 1));
		queue_word(drk_pkg::REQ_PRESS, 8'h01, 8'h80);
		queue_word(drk_pkg::REQ_RELEASE, 8'h44,
			8'(int'(drk_pkg::LAYER_FIRST) + LAYER_ROLES - 1));
		// Control released without a press: the count stays at zero.
		queue_word(drk_pkg::REQ_RELEASE, 8'h66, drk_pkg::MOD_FIRST + drk_pkg::MOD_CTRL);
		queue_word(drk_pkg::REQ_PRESS, 8'h77, drk_pkg::MOD_FIRST + drk_pkg::MOD_SHIFT);
		queue_word(drk_pkg::REQ_RELEASE, 8'h77, drk_pkg::MOD_FIRST + drk_pkg::MOD_SHIFT);
		queue_word(REQ_UNUSED, 8'h00, 8'hFF);
		wait_drained();

		// Random phases. The first opens with a long receiver hold-off.
		load_settings(8'd2, 1'b1, 8'($urandom_range(255)), 8'($urandom_range(255)),
			8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
		rx_holds_asked = rx_holds_asked + 1;
		queue_random_words(18);
		wait_drained();

		// Widest window and all-ones codes, with no idling on either side.
		gaps_on = 1'b0;
		load_settings(8'd255, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		queue_random_words(25);
		wait_drained();
		gaps_on = 1'b1;

		// No tap window at all, all-zero codes.
		load_settings(8'd0, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		queue_random_words(12);
		wait_drained();

		// Role handling switched off: key words leave only the other-key flag behind.
		load_settings(8'd3, 1'b0, 8'h5A, 8'hA5, 8'h3C, 8'hC3, 8'h81);
		queue_random_words(10);
		wait_drained();

		load_settings(8'd1, 1'b1, 8'($urandom_range(255)), 8'($urandom_range(255)),
			8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
		queue_random_words(10);
		wait_drained();
		repeat (20) @(negedge clk);

		if (fail_count == 0 && key_events_due.size() == 0)
			$display("dual_role_key_tap_hold_top test passed");
		else
			$display("dual_role_key_tap_hold_top test failed");
		$finish;
	end

endmodule

`default_nettype wire
